// ===== rtl/rm2q_pkg.sv =====
// Shared constants, types and helpers for the matrix to quaternion block.
package rm2q_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int TOL_W         = 14;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(1);
  localparam int NORM_MSB      = 29;
  localparam int Q_DEPTH       = 2;
  localparam int LANES         = 4;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_e;

  // magnitude width of one unnormalised component, after the normalising shift
  function automatic int mag_width(input int frac);
    int w;
    begin
      w = (frac + 2 > NORM_MSB + 1) ? frac + 2 : NORM_MSB + 1;
      return w;
    end
  endfunction

endpackage

// ===== rtl/rm2q_front.sv =====
// Front end: branch choice and unnormalised quaternion components.
module rm2q_front import rm2q_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MW        = mag_width(FRAC_BITS_DEF)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    push_i,
  input  logic [TOL_W-1:0]        tol_i,
  input  logic signed [IN_W-1:0]  row0_col0_i,
  input  logic signed [IN_W-1:0]  row0_col1_i,
  input  logic signed [IN_W-1:0]  row0_col2_i,
  input  logic signed [IN_W-1:0]  row1_col0_i,
  input  logic signed [IN_W-1:0]  row1_col1_i,
  input  logic signed [IN_W-1:0]  row1_col2_i,
  input  logic signed [IN_W-1:0]  row2_col0_i,
  input  logic signed [IN_W-1:0]  row2_col1_i,
  input  logic signed [IN_W-1:0]  row2_col2_i,
  output logic                    valid_o,
  output logic [LANES*(MW+1)-1:0] word_o
);

  localparam int CW = MW + 1;
  localparam logic signed [CW-1:0] ONE =
    {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [CW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [CW-1:0] t, d, tol;
  logic signed [CW-1:0] c [LANES];
  branch_e              br;
  logic [LANES*(MW+1)-1:0] word_d, word_q;
  logic                 valid_d, valid_q;

  assign a00 = CW'(row0_col0_i);
  assign a01 = CW'(row0_col1_i);
  assign a02 = CW'(row0_col2_i);
  assign a10 = CW'(row1_col0_i);
  assign a11 = CW'(row1_col1_i);
  assign a12 = CW'(row1_col2_i);
  assign a20 = CW'(row2_col0_i);
  assign a21 = CW'(row2_col1_i);
  assign a22 = CW'(row2_col2_i);
  assign tol = signed'(CW'(tol_i));
  assign t   = a00 + a11 + a22 + ONE;

  always_comb begin
    if (t > tol) begin
      br = BR_TRACE;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X;
    end else if (a11 > a22) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end
    d = '0;
    case (br)
      BR_TRACE: begin
        c[0] = a12 - a21; c[1] = a20 - a02; c[2] = a01 - a10; c[3] = t;
      end
      BR_X: begin
        d = ONE + a00 - a11 - a22;
        if (d < 0) d = '0;
        c[0] = d; c[1] = a10 + a01; c[2] = a20 + a02; c[3] = a12 - a21;
      end
      BR_Y: begin
        d = ONE + a11 - a00 - a22;
        if (d < 0) d = '0;
        c[0] = a10 + a01; c[1] = d; c[2] = a21 + a12; c[3] = a20 - a02;
      end
      default: begin
        d = ONE + a22 - a00 - a11;
        if (d < 0) d = '0;
        c[0] = a20 + a02; c[1] = a21 + a12; c[2] = d; c[3] = a01 - a10;
      end
    endcase
    for (int i = 0; i < LANES; i++) begin
      word_d[i*(MW+1) +: MW+1] =
        {c[i][CW-1], MW'(c[i][CW-1] ? -c[i] : c[i])};
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (push_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/rm2q_queue.sv =====
// Short queue between front and back end.
module rm2q_queue import rm2q_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    rd_q, rd_d, wr_q, wr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_pop, do_push;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign ready_o = (cnt_q != NW'(DEPTH)) || do_pop;
  assign do_push = push_i && ready_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/rm2q_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rm2q_isqrt #(
  parameter int SW     = 62,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SW-1:0]     rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SW/2-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NI = SW / 2;

  logic [SW-1:0]     rem_q  [NI];
  logic [SW-1:0]     root_q [NI];
  logic [SIDE_W-1:0] side_q [NI];
  logic              v_q    [NI];

  for (genvar k = 0; k < NI; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
    logic [SW-1:0]     rem_in, root_in, trial;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end
    assign trial = root_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in >> 1;
      end
    end
  end

  assign valid_o = v_q[NI-1];
  assign root_o  = root_q[NI-1][SW/2-1:0];
  assign side_o  = side_q[NI-1];

endmodule

// ===== rtl/rm2q_back.sv =====
// Back end: normalising shift, length, per-lane division and saturation.
module rm2q_back import rm2q_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MW        = mag_width(FRAC_BITS_DEF)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [LANES*(MW+1)-1:0] word_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] quat_o [LANES]
);

  localparam int SW   = 2*MW + 2;
  localparam int LW   = MW + 1;
  localparam int NW   = MW + FRAC_BITS + 1;
  localparam int DW   = NW + 1;
  localparam int QW   = FRAC_BITS + 1;
  localparam int PBW  = $clog2(MW);
  localparam int SHW  = $clog2(NORM_MSB + 1);
  localparam int CAP  = ((1 << FRAC_BITS) < 32767) ? (1 << FRAC_BITS) : 32767;
  localparam int SIDE = 1 + LANES + LANES*MW;

  // stage 0: unpack and largest magnitude
  logic [MW-1:0]    mag_in [LANES];
  logic [LANES-1:0] neg_in;
  logic [MW-1:0]    mx_d;
  logic [MW-1:0]    m0_q [LANES];
  logic [MW-1:0]    mx_q;
  logic [LANES-1:0] n0_q, n1_q, n2_q, n3_q, n4_q, n5_q;
  logic             v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;

  always_comb begin
    mx_d = '0;
    for (int i = 0; i < LANES; i++) begin
      mag_in[i] = word_i[i*(MW+1) +: MW];
      neg_in[i] = word_i[i*(MW+1) + MW];
      if (mag_in[i] > mx_d) mx_d = mag_in[i];
    end
  end

  // stage 1: shift amount
  logic [PBW-1:0] msb;
  logic [SHW-1:0] sh_d, sh_q;
  logic           zero_d, z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [MW-1:0]  m1_q [LANES];

  always_comb begin
    msb = '0;
    for (int b = 0; b < MW; b++) begin
      if (mx_q[b]) msb = PBW'(b);
    end
    zero_d = (mx_q == '0);
    sh_d   = (int'(msb) >= NORM_MSB) ? '0 : SHW'(NORM_MSB - int'(msb));
  end

  // stage 2..5: shift, squares, sums
  logic [MW-1:0]   m2_q [LANES];
  logic [MW-1:0]   m3_q [LANES];
  logic [MW-1:0]   m4_q [LANES];
  logic [MW-1:0]   m5_q [LANES];
  logic [2*MW-1:0] sq_q [LANES];
  logic [2*MW:0]   ps_q [2];
  logic [SW-1:0]   sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
      v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v0_q <= valid_i; v1_q <= v0_q; v2_q <= v1_q;
      v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    sh_q <= sh_d;
    n0_q <= neg_in; n1_q <= n0_q; n2_q <= n1_q;
    n3_q <= n2_q; n4_q <= n3_q; n5_q <= n4_q;
    z1_q <= zero_d; z2_q <= z1_q; z3_q <= z2_q;
    z4_q <= z3_q; z5_q <= z4_q;
    for (int i = 0; i < LANES; i++) begin
      m0_q[i] <= mag_in[i];
      m1_q[i] <= m0_q[i];
      m2_q[i] <= MW'(m1_q[i] << sh_q);
      m3_q[i] <= m2_q[i];
      sq_q[i] <= m2_q[i] * m2_q[i];
      m4_q[i] <= m3_q[i];
      m5_q[i] <= m4_q[i];
    end
    ps_q[0] <= (2*MW+1)'(sq_q[0]) + (2*MW+1)'(sq_q[1]);
    ps_q[1] <= (2*MW+1)'(sq_q[2]) + (2*MW+1)'(sq_q[3]);
    sum_q   <= SW'(ps_q[0]) + SW'(ps_q[1]);
  end

  // length
  logic [SIDE-1:0] side_in, side_out;
  logic            vs;
  logic [SW/2-1:0] root;

  always_comb begin
    side_in[SIDE-1]                 = z5_q;
    side_in[LANES*MW +: LANES]      = n5_q;
    for (int i = 0; i < LANES; i++) begin
      side_in[i*MW +: MW] = m5_q[i];
    end
  end

  rm2q_isqrt #(
    .SW     (SW),
    .SIDE_W (SIDE)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (sum_q),
    .side_i  (side_in),
    .valid_o (vs),
    .root_o  (root),
    .side_o  (side_out)
  );

  // dividend set-up
  logic [LW-1:0]    len_q;
  logic [DW-1:0]    num_q [LANES];
  logic [LANES-1:0] nd_q;
  logic             zd_q, vd_q;
  logic [LW-1:0]    len_s;

  assign len_s = LW'(root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_s;
    nd_q  <= side_out[LANES*MW +: LANES];
    zd_q  <= side_out[SIDE-1];
    for (int i = 0; i < LANES; i++) begin
      num_q[i] <= (DW'(side_out[i*MW +: MW]) << FRAC_BITS) + DW'(len_s >> 1);
    end
  end

  // restoring division, one quotient bit per stage, four lanes side by side
  logic [DW-1:0]    rem_q  [QW][LANES];
  logic [QW-1:0]    quo_q  [QW][LANES];
  logic [LW-1:0]    dl_q   [QW];
  logic [LANES-1:0] dn_q   [QW];
  logic             dz_q   [QW];
  logic             dv_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    logic [DW-1:0]    rem_in [LANES];
    logic [QW-1:0]    quo_in [LANES];
    logic [LW-1:0]    l_in;
    logic [LANES-1:0] n_in;
    logic             z_in, v_in;
    logic [DW-1:0]    dsr;
    if (k == 0) begin : g_first
      assign rem_in = num_q;
      for (genvar i = 0; i < LANES; i++) begin : g_q0
        assign quo_in[i] = '0;
      end
      assign l_in = len_q;
      assign n_in = nd_q;
      assign z_in = zd_q;
      assign v_in = vd_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign l_in   = dl_q[k-1];
      assign n_in   = dn_q[k-1];
      assign z_in   = dz_q[k-1];
      assign v_in   = dv_q[k-1];
    end
    assign dsr = DW'(l_in) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dl_q[k] <= l_in;
      dn_q[k] <= n_in;
      dz_q[k] <= z_in;
      for (int i = 0; i < LANES; i++) begin
        if (rem_in[i] >= dsr) begin
          rem_q[k][i] <= rem_in[i] - dsr;
          quo_q[k][i] <= quo_in[i] | (QW'(1) << J);
        end else begin
          rem_q[k][i] <= rem_in[i];
          quo_q[k][i] <= quo_in[i];
        end
      end
    end
  end

  // saturation and sign
  logic signed [OUT_W-1:0] out_d [LANES];
  logic signed [OUT_W-1:0] out_q [LANES];
  logic [QW-1:0]           qs;
  logic                    vo_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qs = (quo_q[QW-1][i] > QW'(CAP)) ? QW'(CAP) : quo_q[QW-1][i];
      out_d[i] = dn_q[QW-1][i] ? -OUT_W'(qs) : OUT_W'(qs);
      if (dz_q[QW-1]) begin
        out_d[i] = (i == LANES-1) ? OUT_W'(CAP) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = vo_q;
  assign quat_o  = out_q;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion converter, top level.
//
// Usage: drive the nine Q2.FRAC_BITS matrix elements and raise start; a word
// is taken at each rising edge with start high and busy low. The unit
// quaternion leaves on quat_x_o..quat_w_o in Q2.FRAC_BITS, marked by valid_o
// for exactly one cycle. Words leave in the order they were taken.
// Throughput: one word per cycle; the back end never stalls, so busy stays
// low in normal use and only rises if the front-to-back queue were full.
// Pipeline: the result passes the square root, one root bit per stage, and
// the divider, one quotient bit per stage. MW, the component width, is 30
// at FRAC_BITS 14.
// Trace tolerance: written through cfg_we_i / cfg_wdata_i, reset to 1; write
// only while no word is in flight.
// Reset: all valid flags clear at once, the queue empties, no results leave.
// The receiver cannot stall: each result is presented once.
module rotation_matrix_to_quaternion import rm2q_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [TOL_W-1:0]        cfg_wdata_i,
  input  logic signed [IN_W-1:0]  row0_col0_i,
  input  logic signed [IN_W-1:0]  row0_col1_i,
  input  logic signed [IN_W-1:0]  row0_col2_i,
  input  logic signed [IN_W-1:0]  row1_col0_i,
  input  logic signed [IN_W-1:0]  row1_col1_i,
  input  logic signed [IN_W-1:0]  row1_col2_i,
  input  logic signed [IN_W-1:0]  row2_col0_i,
  input  logic signed [IN_W-1:0]  row2_col1_i,
  input  logic signed [IN_W-1:0]  row2_col2_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] quat_x_o,
  output logic signed [OUT_W-1:0] quat_y_o,
  output logic signed [OUT_W-1:0] quat_z_o,
  output logic signed [OUT_W-1:0] quat_w_o
);

  localparam int MW  = mag_width(FRAC_BITS);
  localparam int WW  = LANES * (MW + 1);
  localparam int CAP = ((1 << FRAC_BITS) < 32767) ? (1 << FRAC_BITS) : 32767;

  logic [TOL_W-1:0]        tol_q, tol_d;
  logic                    fv, q_ready, q_valid, load;
  logic [WW-1:0]           f_word, q_word;
  logic signed [OUT_W-1:0] quat [LANES];

  assign tol_d = cfg_we_i ? cfg_wdata_i : tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RST;
    end else begin
      tol_q <= tol_d;
    end
  end

  assign busy = fv && !q_ready;
  assign load = start && !busy;

  rm2q_front #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .push_i      (q_ready),
    .tol_i       (tol_q),
    .row0_col0_i (row0_col0_i),
    .row0_col1_i (row0_col1_i),
    .row0_col2_i (row0_col2_i),
    .row1_col0_i (row1_col0_i),
    .row1_col1_i (row1_col1_i),
    .row1_col2_i (row1_col2_i),
    .row2_col0_i (row2_col0_i),
    .row2_col1_i (row2_col1_i),
    .row2_col2_i (row2_col2_i),
    .valid_o     (fv),
    .word_o      (f_word)
  );

  rm2q_queue #(
    .WIDTH (WW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fv),
    .data_i  (f_word),
    .ready_o (q_ready),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .data_o  (q_word)
  );

  rm2q_back #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .word_i  (q_word),
    .valid_o (valid_o),
    .quat_o  (quat)
  );

  assign quat_x_o = quat[0];
  assign quat_y_o = quat[1];
  assign quat_z_o = quat[2];
  assign quat_w_o = quat[3];

  // back end always drains the queue, so the front never backs up
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("queue backed up");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quat_x_o <= OUT_W'(CAP) && quat_x_o >= -OUT_W'(CAP) &&
                 quat_w_o <= OUT_W'(CAP) && quat_w_o >= -OUT_W'(CAP)))
    else $error("result beyond saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> tol_q == $past(cfg_wdata_i))
    else $error("tolerance write lost");

endmodule
